FILE: rtl/gcb_pkg.sv
// Shared types, constants and the time offset table of the coincidence binner.
package gcb_pkg;

  localparam int MAX_HITS_DEF = 16;
  localparam int NUM_CHANNELS = 48;
  localparam int QDEPTH       = 2;

  localparam logic       OP_EVENT = 1'b0;
  localparam logic       OP_HIT   = 1'b1;
  localparam logic [1:0] HIST_PID = 2'd0;
  localparam logic [1:0] HIST_ET  = 2'd1;
  localparam logic [1:0] HIST_EE  = 2'd2;

  localparam logic signed [31:0] CUT_RESET = -32'sd18000000;

  localparam logic [19:0] AOQ_LO    = 20'd200000;
  localparam logic [19:0] AOQ_HI    = 20'd218000;
  localparam logic [15:0] AOQ_MUL   = 16'd58255;
  localparam int          AOQ_SHIFT = 20;
  localparam logic [9:0]  AOQ_OVF   = 10'd1001;

  localparam logic [13:0] ZET_LO  = 14'd4000;
  localparam logic [13:0] ZET_HI  = 14'd5200;
  localparam logic [9:0]  ZET_OVF = 10'd601;

  localparam logic signed [15:0] E_HI  = 16'sd32000;
  localparam logic [9:0]         E_OVF = 10'd1001;

  localparam logic signed [32:0] T_LO    = -33'sd20000000;
  localparam logic signed [32:0] T_HI    = 33'sd100000000;
  localparam logic [27:0]        T_MUL   = 28'd175921861;
  localparam int                 T_SHIFT = 44;
  localparam logic [10:0]        T_OVF   = 11'd1201;

  typedef struct packed {
    logic               operation;
    logic [19:0]        aoq;
    logic [13:0]        zet;
    logic [5:0]         channel;
    logic signed [15:0] energy;
    logic signed [31:0] hit_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  hist_id;
    logic [9:0]  bin_x;
    logic [10:0] bin_y;
    logic        last;
    logic        hit_dropped;
  } out_t;

  typedef struct packed {
    logic        is_hit;
    logic [9:0]  bin_x;
    logic [10:0] bin_y;
  } qent_t;

  localparam logic signed [16:0] OFFSET_ROM [0:47] = '{
    17'sd25552, 17'sd16668, 17'sd7772, 17'sd10148,
    17'sd3047, -17'sd18387, -17'sd23133, -17'sd6896,
    17'sd14075, -17'sd2379, 17'sd2615, -17'sd2318,
    17'sd9200, 17'sd171, 17'sd6907, 17'sd6225,
    17'sd12758, 17'sd17042, 17'sd1675, 17'sd2764,
    -17'sd9725, -17'sd16153, -17'sd35495, -17'sd9616,
    17'sd16922, -17'sd9201, 17'sd1894, -17'sd7974,
    17'sd2451, -17'sd4479, 17'sd13427, 17'sd3667,
    17'sd10789, 17'sd23379, 17'sd687, 17'sd9430,
    -17'sd4924, -17'sd10756, -17'sd34018, -17'sd23599,
    17'sd12511, -17'sd12621, 17'sd2316, -17'sd7742,
    17'sd1239, -17'sd7211, 17'sd3105, 17'sd8187
  };

  function automatic logic signed [16:0] offset_of(input logic [5:0] ch);
    logic signed [16:0] v;
    v = '0;
    if (ch < 6'(NUM_CHANNELS)) begin
      v = OFFSET_ROM[ch];
    end
    return v;
  endfunction

endpackage

FILE: rtl/gcb_fifo.sv
// Short word queue between the classifying front end and the emitting back end.
module gcb_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gcb_pkg::qent_t push_data,
  output logic          full,
  input  logic          pop,
  output gcb_pkg::qent_t pop_data,
  output logic          empty
);

  localparam int PTR_W = (gcb_pkg::QDEPTH > 1) ? $clog2(gcb_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(gcb_pkg::QDEPTH + 1);

  gcb_pkg::qent_t    mem_r [gcb_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == CNT_W'(gcb_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = p + PTR_W'(1);
    if (p == PTR_W'(gcb_pkg::QDEPTH - 1)) begin
      r = '0;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/gcb_front.sv
// Front end: accepts words, corrects hit time, applies the time cut and computes bins.
module gcb_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gcb_pkg::in_t   in_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data,
  output logic           q_push,
  output gcb_pkg::qent_t q_data,
  input  logic           q_full
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_TIME = 5'b00010,
    F_CLS  = 5'b00100,
    F_MUL  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t             state_r, state_nxt;
  gcb_pkg::in_t        in_r;
  logic signed [31:0]  cut_r;
  logic signed [32:0]  t_r;
  logic                pass_r;
  logic [9:0]          e_bin_r;
  logic [9:0]          z_bin_r;
  logic                a_under_r, a_over_r;
  logic [14:0]         a_d_r;
  logic                t_under_r, t_over_r;
  logic [26:0]         t_d_r;
  logic [9:0]          a_q_r;
  logic [10:0]         t_q_r;

  logic signed [32:0]  t_nxt;
  logic [19:0]         a_diff;
  logic [13:0]         z_diff;
  logic signed [32:0]  t_diff;
  logic [9:0]          e_bin_nxt;
  logic [9:0]          z_bin_nxt;
  logic [30:0]         a_prod;
  logic [54:0]         t_prod;
  logic [9:0]          a_bin;
  logic [10:0]         t_bin;
  logic                is_hit;

  assign in_ready  = (state_r == F_IDLE);
  assign cfg_ready = 1'b1;
  assign is_hit    = (in_r.operation == gcb_pkg::OP_HIT);

  assign t_nxt  = $signed({in_r.hit_time[31], in_r.hit_time})
                - 33'(gcb_pkg::offset_of(in_r.channel));
  assign a_diff = in_r.aoq - gcb_pkg::AOQ_LO;
  assign z_diff = in_r.zet - gcb_pkg::ZET_LO;
  assign t_diff = t_r - gcb_pkg::T_LO;

  always_comb begin
    if (in_r.energy[15]) begin
      e_bin_nxt = '0;
    end else if (in_r.energy >= gcb_pkg::E_HI) begin
      e_bin_nxt = gcb_pkg::E_OVF;
    end else begin
      e_bin_nxt = in_r.energy[14:5] + 10'd1;
    end
    if (in_r.zet < gcb_pkg::ZET_LO) begin
      z_bin_nxt = '0;
    end else if (in_r.zet >= gcb_pkg::ZET_HI) begin
      z_bin_nxt = gcb_pkg::ZET_OVF;
    end else begin
      z_bin_nxt = z_diff[10:1] + 10'd1;
    end
  end

  assign a_prod = {16'b0, a_d_r} * {15'b0, gcb_pkg::AOQ_MUL};
  assign t_prod = {28'b0, t_d_r} * {27'b0, gcb_pkg::T_MUL};

  always_comb begin
    if (a_under_r) begin
      a_bin = '0;
    end else if (a_over_r) begin
      a_bin = gcb_pkg::AOQ_OVF;
    end else begin
      a_bin = a_q_r + 10'd1;
    end
    if (t_under_r) begin
      t_bin = '0;
    end else if (t_over_r) begin
      t_bin = gcb_pkg::T_OVF;
    end else begin
      t_bin = t_q_r + 11'd1;
    end
  end

  always_comb begin
    q_data.is_hit = is_hit;
    if (is_hit) begin
      q_data.bin_x = e_bin_r;
      q_data.bin_y = t_bin;
    end else begin
      q_data.bin_x = a_bin;
      q_data.bin_y = {1'b0, z_bin_r};
    end
  end

  assign q_push = (state_r == F_PUSH) && (!is_hit || pass_r) && !q_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_TIME;
        end
      end
      F_TIME: state_nxt = F_CLS;
      F_CLS:  state_nxt = F_MUL;
      F_MUL:  state_nxt = F_PUSH;
      F_PUSH: begin
        if ((is_hit && !pass_r) || !q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cut_r   <= gcb_pkg::CUT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        cut_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      in_r <= in_data;
    end
    if (state_r == F_TIME) begin
      t_r <= t_nxt;
    end
    if (state_r == F_CLS) begin
      pass_r    <= (t_r >= $signed({cut_r[31], cut_r}));
      e_bin_r   <= e_bin_nxt;
      z_bin_r   <= z_bin_nxt;
      a_under_r <= (in_r.aoq < gcb_pkg::AOQ_LO);
      a_over_r  <= (in_r.aoq >= gcb_pkg::AOQ_HI);
      a_d_r     <= a_diff[14:0];
      t_under_r <= (t_r < gcb_pkg::T_LO);
      t_over_r  <= (t_r >= gcb_pkg::T_HI);
      t_d_r     <= t_diff[26:0];
    end
    if (state_r == F_MUL) begin
      a_q_r <= a_prod[gcb_pkg::AOQ_SHIFT +: 10];
      t_q_r <= t_prod[gcb_pkg::T_SHIFT +: 11];
    end
  end

endmodule

FILE: rtl/gcb_back.sv
// Back end: keeps the hit store and emits the bin increments of each queued word.
module gcb_back #(
  parameter int MAX_HITS = gcb_pkg::MAX_HITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  gcb_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output gcb_pkg::out_t  out_data
);

  localparam int CNT_W = $clog2(MAX_HITS + 1);
  localparam int IDX_W = $clog2(MAX_HITS);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ET   = 4'b0010,
    B_PA   = 4'b0100,
    B_PB   = 4'b1000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] idx_r;
  gcb_pkg::qent_t   ent_r;
  logic             full_r;
  logic [9:0]       mem_r [MAX_HITS];
  logic [9:0]       rd_r;
  logic [9:0]       oth_r;
  logic             out_valid_r;
  gcb_pkg::out_t    out_r;

  logic             slot_free;
  logic             emit;
  logic             store_full;
  logic             wr_en;
  gcb_pkg::out_t    res;
  logic             res_done;

  assign slot_free  = !out_valid_r || out_ready;
  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign store_full = (cnt_r == CNT_W'(MAX_HITS));
  assign wr_en      = q_pop && q_data.is_hit && !store_full;
  assign emit       = slot_free && (state_r != B_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_comb begin
    res      = '0;
    res_done = 1'b0;
    unique case (state_r)
      B_ET: begin
        res.bin_x = ent_r.bin_x;
        res.bin_y = ent_r.bin_y;
        if (ent_r.is_hit) begin
          res.hist_id     = gcb_pkg::HIST_ET;
          res.hit_dropped = full_r;
          res_done        = full_r || (n_r == '0);
        end else begin
          res.hist_id = gcb_pkg::HIST_PID;
          res_done    = 1'b1;
        end
        res.last = res_done;
      end
      B_PA: begin
        res.hist_id = gcb_pkg::HIST_EE;
        res.bin_x   = ent_r.bin_x;
        res.bin_y   = {1'b0, rd_r};
      end
      B_PB: begin
        res.hist_id = gcb_pkg::HIST_EE;
        res.bin_x   = oth_r;
        res.bin_y   = {1'b0, ent_r.bin_x};
        res_done    = (CNT_W'(idx_r) == n_r);
        res.last    = res_done;
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          state_nxt = B_ET;
        end
      end
      B_ET: begin
        if (emit) begin
          state_nxt = res_done ? B_IDLE : B_PA;
        end
      end
      B_PA: begin
        if (emit) begin
          state_nxt = B_PB;
        end
      end
      B_PB: begin
        if (emit) begin
          state_nxt = res_done ? B_IDLE : B_PA;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        if (!q_data.is_hit) begin
          cnt_r <= '0;
        end else if (!store_full) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r  <= q_data;
      full_r <= store_full;
      n_r    <= cnt_r;
      idx_r  <= '0;
    end
    if (state_r == B_PA && emit) begin
      oth_r <= rd_r;
      idx_r <= idx_r + IDX_W'(1);
    end
    if (emit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[cnt_r[IDX_W-1:0]] <= q_data.bin_x;
    end
    rd_r <= mem_r[idx_r];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_HITS))
    else $error("Hit count exceeds the store size.");

  a_pair_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_PA |-> CNT_W'(idx_r) < n_r)
    else $error("Pair index is past the stored hits.");

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.hit_dropped |-> out_r.last && out_r.hist_id == gcb_pkg::HIST_ET)
    else $error("Dropped hit flag on a word that is not a final energy-time word.");

  a_event_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && !q_data.is_hit |=> cnt_r == '0)
    else $error("Event start did not empty the hit store.");

endmodule

FILE: rtl/gamma_coincidence_binner_top.sv
// The front end takes no new input word before it has finished the last; the back
// end emits one result word for an event start or a non-pairing hit and 1 + 2*n
// words for a hit pairing with n stored hits, one result word per cycle at most,
// set by the single output register.
// Reset is synchronous and active low; it empties the hit store and the queue and
// loads the time cut with -18000000 ps. No clearing pass is needed after reset.
module gamma_coincidence_binner_top #(
  parameter int MAX_HITS = gcb_pkg::MAX_HITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gcb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gcb_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  gcb_pkg::qent_t q_wdata;
  gcb_pkg::qent_t q_rdata;

  gcb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  gcb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  gcb_back #(
    .MAX_HITS (MAX_HITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sim/gamma_coincidence_binner_top_tb.sv
// Testbench of the gamma coincidence binner: predicts every bin word and checks it.
module gamma_coincidence_binner_top_tb;

  localparam int STORE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;

  localparam int CH_OFFSET [0:47] = '{
    25552, 16668, 7772, 10148, 3047, -18387, -23133, -6896,
    14075, -2379, 2615, -2318, 9200, 171, 6907, 6225,
    12758, 17042, 1675, 2764, -9725, -16153, -35495, -9616,
    16922, -9201, 1894, -7974, 2451, -4479, 13427, 3667,
    10789, 23379, 687, 9430, -4924, -10756, -34018, -23599,
    12511, -12621, 2316, -7742, 1239, -7211, 3105, 8187
  };

  class coinc_bins;
    longint         cut;
    logic [9:0]     ebins [STORE_DEPTH];
    int             nstored;
    gcb_pkg::out_t  due_bins [$];
    int             errors;
    int             n_checked;
    int             n_full;
    int             n_below_cut;

    function new();
      cut = -18000000;
      nstored = 0;
      errors = 0;
      n_checked = 0;
      n_full = 0;
      n_below_cut = 0;
    endfunction

    function int crystal_offset(logic [5:0] ch);
      int off;
      off = 0;
      if (ch < 6'd48) begin
        off = CH_OFFSET[ch];
      end
      return off;
    endfunction

    function int unsigned uniform_bin(longint v, longint lo, longint width, longint n);
      if (v < lo) begin
        return 0;
      end
      if (v >= lo + n * width) begin
        return int'(n + 1);
      end
      return int'((v - lo) / width + 1);
    endfunction

    function void push_bin(logic [1:0] id, int unsigned bx, int unsigned by, bit fin,
                           bit drop);
      gcb_pkg::out_t r;
      r.hist_id = id;
      r.bin_x = 10'(bx);
      r.bin_y = 11'(by);
      r.last = fin;
      r.hit_dropped = drop;
      due_bins.push_back(r);
    endfunction

    function void note_word(gcb_pkg::in_t w);
      longint      t;
      int unsigned ebin;
      int unsigned tbin;
      if (w.operation == gcb_pkg::OP_EVENT) begin
        push_bin(gcb_pkg::HIST_PID, uniform_bin(longint'(w.aoq), 200000, 18, 1000),
                 uniform_bin(longint'(w.zet), 4000, 2, 600), 1'b1, 1'b0);
        nstored = 0;
        return;
      end
      t = longint'($signed(w.hit_time)) - longint'(crystal_offset(w.channel));
      if (t < cut) begin
        n_below_cut++;
        return;
      end
      ebin = uniform_bin(longint'($signed(w.energy)), 0, 32, 1000);
      tbin = uniform_bin(t, -20000000, 100000, 1200);
      if (nstored >= STORE_DEPTH) begin
        n_full++;
        push_bin(gcb_pkg::HIST_ET, ebin, tbin, 1'b1, 1'b1);
        return;
      end
      push_bin(gcb_pkg::HIST_ET, ebin, tbin, nstored == 0, 1'b0);
      for (int i = 0; i < nstored; i++) begin
        push_bin(gcb_pkg::HIST_EE, ebin, ebins[i], 1'b0, 1'b0);
        push_bin(gcb_pkg::HIST_EE, ebins[i], ebin, i == nstored - 1, 1'b0);
      end
      ebins[nstored] = 10'(ebin);
      nstored++;
    endfunction

    function void compare_field(string name, int unsigned want, logic [10:0] got);
      if (got !== 11'(want)) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_bin(gcb_pkg::out_t got);
      gcb_pkg::out_t want;
      if (due_bins.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got hist %0d x %0d y %0d",
                 $time, got.hist_id, got.bin_x, got.bin_y);
        return;
      end
      want = due_bins.pop_front();
      n_checked++;
      compare_field("hist_id", want.hist_id, 11'(got.hist_id));
      compare_field("bin_x", want.bin_x, 11'(got.bin_x));
      compare_field("bin_y", want.bin_y, got.bin_y);
      compare_field("last", want.last, 11'(got.last));
      compare_field("hit_dropped", want.hit_dropped, 11'(got.hit_dropped));
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  gcb_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  gcb_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [31:0]   cfg_data = '0;

  coinc_bins     sb = new();
  bit            calm = 1'b0;
  int            n_words = 0;
  int            n_cuts = 0;

  gamma_coincidence_binner_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_bin(out_data);
    end
    out_ready <= calm || ($urandom_range(0, 99) >= 12);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d words still due", $time, sb.due_bins.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic gcb_pkg::in_t mk_hit(logic [5:0] ch, logic [15:0] e, logic [31:0] t);
    gcb_pkg::in_t w;
    w.operation = gcb_pkg::OP_HIT;
    w.aoq = 20'($urandom());
    w.zet = 14'($urandom());
    w.channel = ch;
    w.energy = e;
    w.hit_time = t;
    return w;
  endfunction

  function automatic gcb_pkg::in_t mk_event(logic [19:0] a, logic [13:0] z);
    gcb_pkg::in_t w;
    w.operation = gcb_pkg::OP_EVENT;
    w.aoq = a;
    w.zet = z;
    w.channel = 6'($urandom());
    w.energy = 16'($urandom());
    w.hit_time = $urandom();
    return w;
  endfunction

  function automatic gcb_pkg::in_t rand_hit();
    logic [5:0] ch;
    int         e;
    longint     t;
    ch = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0, 1: e = int'($urandom_range(0, 65535));
      default: e = int'($urandom_range(0, 32100)) - 50;
    endcase
    case ($urandom_range(0, 9))
      0: t = longint'($urandom());
      1: t = 2147483647 - longint'($urandom_range(0, 40000));
      2: t = sb.cut + sb.crystal_offset(ch) + longint'($urandom_range(0, 4)) - 2;
      default: t = longint'($urandom_range(0, 122000000)) - 21000000;
    endcase
    return mk_hit(ch, 16'(e), 32'(t));
  endfunction

  function automatic gcb_pkg::in_t rand_event();
    logic [19:0] a;
    logic [13:0] z;
    a = $urandom_range(0, 1) ? 20'($urandom_range(0, 1048575))
                             : 20'($urandom_range(199990, 218010));
    z = $urandom_range(0, 1) ? 14'($urandom_range(0, 16383))
                             : 14'($urandom_range(3990, 5210));
    return mk_event(a, z);
  endfunction

  task automatic send_word(input gcb_pkg::in_t w);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 12);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    n_words++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cut(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.cut = longint'($signed(v));
    n_cuts++;
    cfg_valid <= 1'b0;
  endtask

  // Mostly whole events of low multiplicity, now and then a crowded one that
  // can overflow the hit store, and some stray hits sent just before an event start.
  task automatic run_events(input int budget);
    int sent;
    int mult;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(rand_hit());
        sent++;
      end
      send_word(rand_event());
      sent++;
      mult = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 5);
      repeat (mult) send_word(rand_hit());
      sent += mult;
    end
  endtask

  initial begin
    logic [31:0] cut_steps [5];
    int          budgets [5];
    cut_steps = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'd0,
                  32'(int'($urandom_range(0, 120000000)) - 20000000),
                  32'(gcb_pkg::CUT_RESET)};
    budgets = '{30, 15, 30, 35, 35};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(mk_hit(6'd0, 16'd0, 32'd0));
    send_word(mk_hit(6'd63, 16'h8000, 32'h7FFF_FFFF));
    send_word(mk_hit(6'd47, 16'h7FFF, 32'(-18000000 + 8187)));
    send_word(mk_hit(6'd22, 16'd31999, 32'(100000000 - 35495 - 1)));
    send_word(mk_hit(6'd5, 16'd32000, 32'(-18000001 - 18387)));
    send_word(mk_event(20'd0, 14'd0));
    send_word(mk_event(20'hFFFFF, 14'h3FFF));
    send_word(mk_event(20'd200000, 14'd5199));
    send_word(mk_event(20'd217999, 14'd4000));
    for (int k = 0; k < STORE_DEPTH + 1; k++) begin
      send_word(mk_hit(6'(k * 3), 16'(k * 2000 - 1000), 32'(k * 3000000)));
    end
    settle();

    for (int p = 0; p < 5; p++) begin
      write_cut(cut_steps[p]);
      calm = (p == 2);
      run_events(budgets[p]);
      settle();
    end
    calm = 1'b0;

    $display("Sent %0d input words under %0d time cut settings; %0d bin words checked.",
             n_words, n_cuts, sb.n_checked);
    $display("Hits below the cut: %0d, hits that found the store full: %0d.",
             sb.n_below_cut, sb.n_full);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
